@@ hdl/asfp_pkg.sv @@
// Shared types, constants and lookup functions for the AMR storage frame parser.
`default_nettype none

package asfp_pkg;

  localparam int unsigned CounterWidthDef = 24;
  localparam int unsigned CntOutW         = 24;
  localparam int unsigned SeekW           = 24;
  localparam int unsigned PaddrW          = 3;
  localparam int unsigned PdataW          = 32;

  localparam logic [2:0] HdrLen = 3'd6;

  localparam logic [7:0] FrameDurRst = 8'd20;
  localparam logic [SeekW-1:0] SeekTgtRst = '0;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_TYPE    = 2'd1,
    ROLE_PAYLOAD = 2'd2
  } role_e;

  typedef enum logic {
    REG_FRAME_DUR = 1'b0,
    REG_SEEK_TGT  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    role_e              byte_role;
    logic [3:0]         frame_type;
    logic [4:0]         frame_size;
    logic               last_of_frame;
    logic               header_ok;
    logic [CntOutW-1:0] frames_done;
    logic [CntOutW-1:0] elapsed_ms;
    logic [CntOutW-1:0] payload_total;
    logic               before_target;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       frame_duration_ms;
    logic [SeekW-1:0] seek_target_ms;
  } cfg_t;

  // "#!AMR\n"
  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0:    val = 8'h23;
      3'd1:    val = 8'h21;
      3'd2:    val = 8'h41;
      3'd3:    val = 8'h4D;
      3'd4:    val = 8'h52;
      3'd5:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [4:0] payload_len(input logic [3:0] ftype);
    logic [4:0] len;
    case (ftype)
      4'd0:    len = 5'd12;
      4'd1:    len = 5'd13;
      4'd2:    len = 5'd15;
      4'd3:    len = 5'd17;
      4'd4:    len = 5'd19;
      4'd5:    len = 5'd20;
      4'd6:    len = 5'd26;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd5;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hdl/asfp_cfg_regs.sv @@
// APB configuration registers: frame duration and seek target.
`default_nettype none

module asfp_cfg_regs
  import asfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FRAME_DUR: cfg_d.frame_duration_ms = pwdata[7:0];
        REG_SEEK_TGT:  cfg_d.seek_target_ms    = pwdata[SeekW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_DUR: prdata = PdataW'(cfg_q.frame_duration_ms);
      REG_SEEK_TGT:  prdata = PdataW'(cfg_q.seek_target_ms);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_duration_ms <= FrameDurRst;
      cfg_q.seek_target_ms    <= SeekTgtRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/asfp_parser.sv @@
// Header check, frame splitting and saturating counters for one byte per step.
`default_nettype none

module asfp_parser
  import asfp_pkg::*;
#(
  parameter int unsigned CounterWidth = CounterWidthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  in_item_t      item_i,
  input  cfg_t          cfg_i,
  output out_item_t     res_o
);

  localparam int unsigned CmpW = (CounterWidth > SeekW) ? CounterWidth : SeekW;
  localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};

  logic [2:0]              hp_q, hp_d, hp;
  logic                    hm_q, hm_d, hm;
  logic [4:0]              rem_q, rem_d, rem;
  logic [3:0]              type_q, type_d, ftype;
  logic [4:0]              size_q, size_d, fsize;
  logic [CounterWidth-1:0] frm_q, frm_d, frm;
  logic [CounterWidth-1:0] tim_q, tim_d, tim;
  logic [CounterWidth-1:0] sum_q, sum_d, sum;
  logic [CounterWidth:0]   frm_inc, tim_inc, sum_inc;
  logic                    sof, last, before_tgt;
  role_e                   role;
  logic [7:0]              b;

  assign b   = item_i.data_byte;
  assign sof = item_i.start_of_file;

  // Start of file restarts everything before this byte is looked at.
  always_comb begin
    hp  = sof ? '0   : hp_q;
    hm  = sof ? 1'b1 : hm_q;
    rem = sof ? '0   : rem_q;
    frm = sof ? '0   : frm_q;
    tim = sof ? '0   : tim_q;
    sum = sof ? '0   : sum_q;
  end

  assign frm_inc = {1'b0, frm} + (CounterWidth+1)'(1);
  assign tim_inc = {1'b0, tim} + (CounterWidth+1)'(cfg_i.frame_duration_ms);

  always_comb begin
    hp_d       = hp;
    hm_d       = hm;
    rem_d      = rem;
    type_d     = sof ? '0 : type_q;
    size_d     = sof ? '0 : size_q;
    frm_d      = frm;
    tim_d      = tim;
    sum_d      = sum;
    role       = ROLE_HEADER;
    ftype      = '0;
    fsize      = '0;
    last       = 1'b0;
    before_tgt = 1'b0;
    sum_inc    = '0;
    if (hp < HdrLen) begin
      if (b != magic_byte(hp)) hm_d = 1'b0;
      hp_d = hp + 3'd1;
    end else if (hm) begin
      if (rem == '0) begin
        type_d = b[6:3];
        size_d = payload_len(b[6:3]);
        rem_d  = size_d;
        role   = ROLE_TYPE;
        last   = (size_d == '0);
      end else begin
        rem_d = rem - 5'd1;
        role  = ROLE_PAYLOAD;
        last  = (rem_d == '0);
      end
      ftype      = type_d;
      fsize      = size_d;
      before_tgt = CmpW'(tim) < CmpW'(cfg_i.seek_target_ms);
      sum_inc    = {1'b0, sum} + (CounterWidth+1)'(size_d);
      if (last) begin
        frm_d = frm_inc[CounterWidth] ? CntMax : frm_inc[CounterWidth-1:0];
        tim_d = tim_inc[CounterWidth] ? CntMax : tim_inc[CounterWidth-1:0];
        sum_d = sum_inc[CounterWidth] ? CntMax : sum_inc[CounterWidth-1:0];
      end
    end
  end

  always_comb begin
    res_o.byte_out      = b;
    res_o.byte_role     = role;
    res_o.frame_type    = ftype;
    res_o.frame_size    = fsize;
    res_o.last_of_frame = last;
    res_o.header_ok     = (hp_d >= HdrLen) && hm_d;
    res_o.frames_done   = CntOutW'(frm_d);
    res_o.elapsed_ms    = CntOutW'(tim);
    res_o.payload_total = CntOutW'(sum_d);
    res_o.before_target = before_tgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q   <= '0;
      hm_q   <= 1'b1;
      rem_q  <= '0;
      type_q <= '0;
      size_q <= '0;
      frm_q  <= '0;
      tim_q  <= '0;
      sum_q  <= '0;
    end else if (step_i) begin
      hp_q   <= hp_d;
      hm_q   <= hm_d;
      rem_q  <= rem_d;
      type_q <= type_d;
      size_q <= size_d;
      frm_q  <= frm_d;
      tim_q  <= tim_d;
      sum_q  <= sum_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/amr_storage_frame_parser_top.sv @@
// Top level of the AMR storage frame parser: input stage, parser, result stage, APB.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------
//   in      | in_valid_i/in_ready_o | in_data_i  (in_item_t)
//   out     | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   cfg     | APB psel/penable/pready | paddr, pwdata, prdata
//
// One byte per cycle sustained while the output is not stalled; a byte enters the input
// register at its transfer, and its result shows on the output when it moves on into
// the result register. Reset clears both valid flags and returns the parser state and
// the configuration registers to their reset values. A stall on the output holds the
// result register and the input register; the input side keeps taking bytes as long
// as the input register can drain.
`default_nettype none

module amr_storage_frame_parser_top
  import asfp_pkg::*;
#(
  parameter int unsigned CounterWidth = CounterWidthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  out_item_t res;
  cfg_t      cfg;
  logic      out_free, s1_adv, in_fire;

  asfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the parser state only when the byte moves into the result register.
  asfp_parser #(
    .CounterWidth (CounterWidth)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // The result register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)     s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s1_adv)           out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q  <= in_data_i;
    if (s1_adv)  out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ hdl/asfp_checker.sv @@
// Port-level checks for the AMR storage frame parser, bound to the top level.
`default_nettype none

module asfp_checker
  import asfp_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input out_item_t out_data_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_role == ROLE_HEADER |->
      out_data_o.frame_type == '0 && out_data_o.frame_size == '0 &&
      !out_data_o.last_of_frame && !out_data_o.before_target)
    else $error("header byte carries frame information");

  a_frame_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_role != ROLE_HEADER |-> out_data_o.header_ok)
    else $error("frame byte without a matched header");

  a_type_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_role == ROLE_TYPE && out_data_o.last_of_frame |->
      out_data_o.frame_size == '0)
    else $error("type byte ends a frame with payload");

endmodule

bind amr_storage_frame_parser_top asfp_checker u_asfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the AMR storage frame parser top level.
`timescale 1ns / 100ps

module tb;
  import asfp_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 96;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReports = 10;
  localparam logic [CntOutW-1:0] CountMax = '1;

  // "#!AMR" plus line feed, first byte in the top octet
  localparam logic [47:0] AMR_MAGIC = 48'h23_21_41_4D_52_0A;
  // payload bytes per frame type, type 0 in the low five bits
  localparam logic [79:0] PAYLOAD_LENS = {
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd5,
    5'd31, 5'd26, 5'd20, 5'd19, 5'd17, 5'd15, 5'd13, 5'd12
  };

  // Tracks the parser state, predicts one result per accepted byte and checks
  // results in order against the predictions.
  class amr_frame_scoreboard;
    logic [7:0]         duration_ms;
    logic [SeekW-1:0]   seek_ms;
    logic [2:0]         hdr_pos;
    logic               hdr_match;
    logic [4:0]         remaining;
    logic [3:0]         cur_type;
    logic [4:0]         cur_size;
    logic [CntOutW-1:0] frames;
    logic [CntOutW-1:0] clock_ms;
    logic [CntOutW-1:0] size_total;
    out_item_t          pending[$];
    int                 errors;

    function new();
      duration_ms = FrameDurRst;
      seek_ms = SeekTgtRst;
      errors = 0;
      restart();
    endfunction

    function void restart();
      hdr_pos = '0;
      hdr_match = 1'b1;
      remaining = '0;
      cur_type = '0;
      cur_size = '0;
      frames = '0;
      clock_ms = '0;
      size_total = '0;
    endfunction

    function logic [CntOutW-1:0] sat_add(logic [CntOutW-1:0] a, logic [CntOutW-1:0] b);
      logic [CntOutW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CntOutW] ? CountMax : sum[CntOutW-1:0];
    endfunction

    function void note_byte(in_item_t it);
      out_item_t          want;
      logic [CntOutW-1:0] start_ms;
      logic               last;
      want = '0;
      last = 1'b0;
      if (it.start_of_file) restart();
      start_ms = clock_ms;
      want.byte_role = ROLE_HEADER;
      if (hdr_pos < HdrLen) begin
        if (it.data_byte != AMR_MAGIC[8*(5-int'(hdr_pos)) +: 8]) hdr_match = 1'b0;
        hdr_pos = hdr_pos + 3'd1;
      end else if (hdr_match) begin
        if (remaining == '0) begin
          cur_type = it.data_byte[6:3];
          cur_size = PAYLOAD_LENS[5*int'(cur_type) +: 5];
          remaining = cur_size;
          want.byte_role = ROLE_TYPE;
          last = (cur_size == '0);
        end else begin
          remaining = remaining - 5'd1;
          want.byte_role = ROLE_PAYLOAD;
          last = (remaining == '0);
        end
        want.frame_type = cur_type;
        want.frame_size = cur_size;
        want.before_target = (start_ms < seek_ms);
        if (last) begin
          frames = sat_add(frames, CntOutW'(1));
          clock_ms = sat_add(clock_ms, CntOutW'(duration_ms));
          size_total = sat_add(size_total, CntOutW'(cur_size));
        end
      end
      want.byte_out = it.data_byte;
      want.last_of_frame = last;
      want.header_ok = (hdr_pos >= HdrLen) && hdr_match;
      want.frames_done = frames;
      want.elapsed_ms = start_ms;
      want.payload_total = size_total;
      pending.push_back(want);
    endfunction

    function string show(out_item_t r);
      return $sformatf({"byte %02h role %0d type %0d size %0d last %0b hdr %0b ",
                        "frames %0d ms %0d tot %0d bt %0b"},
                       r.byte_out, r.byte_role, r.frame_type, r.frame_size, r.last_of_frame,
                       r.header_ok, r.frames_done, r.elapsed_ms, r.payload_total,
                       r.before_target);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("result with nothing pending: %s", show(got));
        return;
      end
      want = pending.pop_front();
      if (got.byte_out !== want.byte_out || got.byte_role !== want.byte_role ||
          got.frame_type !== want.frame_type || got.frame_size !== want.frame_size ||
          got.last_of_frame !== want.last_of_frame || got.header_ok !== want.header_ok ||
          got.frames_done !== want.frames_done || got.elapsed_ms !== want.elapsed_ms ||
          got.payload_total !== want.payload_total ||
          got.before_target !== want.before_target) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("mismatch %0d expected: %s", errors, show(want));
          $display("mismatch %0d actual:   %s", errors, show(got));
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  amr_frame_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  quiet_cycles;

  amr_storage_frame_parser_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver: stall at random, or hold off for a long stretch on request so the
  // pipeline fills and back-pressure reaches the input side.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) sb.check_result(out_data_o);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one byte, idling at random first; return at the edge of its transfer.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    in_item_t it;
    it.data_byte = b;
    it.start_of_file = sof;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(it);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup and access phases, then an idle gap with psel low so writes never overlap.
  task automatic apb_write(input reg_idx_e idx, input logic [PdataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_FRAME_DUR) sb.duration_ms = val[7:0];
    else sb.seek_ms = val[SeekW-1:0];
  endtask

  task automatic set_config(input logic [7:0] dur, input logic [SeekW-1:0] seek);
    wait_drained();
    apb_write(REG_FRAME_DUR, PdataW'(dur));
    apb_write(REG_SEEK_TGT, PdataW'(seek));
  endtask

  // Mostly well-formed files with random frames; the rest is noise, corrupt
  // headers, missing file starts and truncated frames.
  task automatic stream_files(input int n_bytes);
    int         sent;
    int         kind;
    int         flaw;
    int         n_frames;
    int         len;
    logic [7:0] b;
    logic [3:0] t;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        send_byte(8'($urandom), $urandom_range(15) == 0);
        sent++;
      end else begin
        flaw = (kind < 22) ? $urandom_range(0, 7) : 8;
        for (int i = 0; i < 6; i++) begin
          b = AMR_MAGIC[8*(5-i) +: 8];
          if (flaw == i) b = 8'($urandom);
          send_byte(b, i == 0 && flaw != 7);
        end
        sent += 6;
        n_frames = $urandom_range(1, 5);
        for (int f = 0; f < n_frames; f++) begin
          t = 4'($urandom);
          send_byte({1'($urandom), t, 3'($urandom)}, 1'b0);
          len = PAYLOAD_LENS[5*int'(t) +: 5];
          if (flaw == 6 && f == n_frames - 1) len = $urandom_range(0, len);
          for (int j = 0; j < len; j++) send_byte(8'($urandom), 1'b0);
          sent += len + 1;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First bytes after reset without a file-start mark: still a valid header.
    for (int i = 0; i < 6; i++) send_byte(AMR_MAGIC[8*(5-i) +: 8], 1'b0);
    // SID frame with the unused type-byte bits set, extreme payload bytes.
    send_byte(8'hC7, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    // Zero-length frames: type 15 and type 9.
    send_byte(8'h78, 1'b0);
    send_byte(8'h4F, 1'b0);
    // Failed header on a new file: later bytes stay header bytes.
    send_byte(8'h23, 1'b1);
    send_byte(8'h21, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h52, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h40, 1'b0);

    // Sender idles often, receiver stalls most of the time.
    set_config(8'd255, '1);
    send_idle_pct = 35;
    recv_stall_pct = 88;
    stream_files(450);

    // Swap the idling sides; zero frame duration keeps elapsed time at zero.
    set_config(8'd0, '0);
    send_idle_pct = 88;
    recv_stall_pct = 35;
    stream_files(450);

    // Full rate, with one long receiver hold-off to back up the input side.
    set_config(8'd1, SeekW'($urandom_range(0, 6)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    stream_files(450);

    set_config(8'($urandom_range(2, 254)), SeekW'($urandom_range(0, 150)));
    stream_files(450);

    // Back-to-back zero-length frames against a seek target near the top.
    set_config(8'd255, 24'hFFFFFE);
    for (int i = 0; i < 6; i++) send_byte(AMR_MAGIC[8*(5-i) +: 8], i == 0);
    repeat (30) send_byte({1'($urandom), 4'($urandom_range(9, 15)), 3'($urandom)}, 1'b0);

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
